@@ hw/rtl/polynomial_audio_residual_codec_assert.svh @@
// ----------------------------------------------------------------------------
// polynomial_audio_residual_codec_assert.svh
// concurrent assertion macros shared by parc_history and the top codec module
// the asserting module must have clk and rst_n in scope
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_AUDIO_RESIDUAL_CODEC_ASSERT_SVH
`define POLYNOMIAL_AUDIO_RESIDUAL_CODEC_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PARC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parc assertion failed");

// next-cycle implication
`define PARC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parc assertion failed");

`else

`define PARC_ASSERT_IMP(lbl, ante, cons)
`define PARC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/parc_pkg.sv @@
// ----------------------------------------------------------------------------
// parc_pkg
// types and constants of the polynomial audio residual codec
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package parc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORDER     = 2'd0,
        REG_CHAN_MODE = 2'd1,
        REG_STEREO    = 2'd2,
        REG_DECODE    = 2'd3
    } cfg_reg_t;

    // predictor order codes
    localparam logic [1:0] ORDER_1 = 2'd1;
    localparam logic [1:0] ORDER_2 = 2'd2;
    localparam logic [1:0] ORDER_3 = 2'd3;

    // stereo channel modes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_MID  = 2'd1;
    localparam logic [1:0] MODE_SIDE = 2'd2;

    // live configuration handed to the predictor
    typedef struct packed {
        logic [1:0] order;
        logic [1:0] chan_mode;
        logic       stereo;
        logic       decode;
    } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/parc_history.sv @@
// ----------------------------------------------------------------------------
// parc_history
// shift line of past samples with block-start clear
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "polynomial_audio_residual_codec_assert.svh"

module parc_history #(
    parameter int HISTORY_DEPTH = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          clear,
    input  wire logic                          shift,
    input  wire logic [parc_pkg::SAMPLE_W-1:0] new_sample,
    output logic      [parc_pkg::SAMPLE_W-1:0] taps [HISTORY_DEPTH]
);

    logic [parc_pkg::SAMPLE_W-1:0] hist_reg  [HISTORY_DEPTH];
    logic [parc_pkg::SAMPLE_W-1:0] hist_next [HISTORY_DEPTH];

    // taps seen by the current item, zero when its block starts here
    always_comb
    begin
        for (int k = 0; k < HISTORY_DEPTH; k++)
        begin
            taps[k] = clear ? '0 : hist_reg[k];
        end
    end

    // shift in the newest sample
    always_comb
    begin
        for (int k = 0; k < HISTORY_DEPTH; k++)
        begin
            hist_next[k] = hist_reg[k];
        end
        if (shift)
        begin
            hist_next[0] = new_sample;
            for (int k = 1; k < HISTORY_DEPTH; k++)
            begin
                hist_next[k] = taps[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HISTORY_DEPTH; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < HISTORY_DEPTH; k++)
            begin
                hist_reg[k] <= hist_next[k];
            end
        end
    end

    // block start leaves only the newest sample behind
    `PARC_ASSERT_NXT(a_clear_old, shift && clear, hist_reg[1] == '0)
    // history holds between transfers
    `PARC_ASSERT_NXT(a_hold, !shift, hist_reg[0] == $past(hist_reg[0]))

endmodule

`default_nettype wire

@@ hw/rtl/parc_predict.sv @@
// ----------------------------------------------------------------------------
// parc_predict
// fixed polynomial predictor over the sample history
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module parc_predict #(
    parameter int HISTORY_DEPTH = 6
) (
    input  wire parc_pkg::cfg_t                cfg,
    input  wire logic [parc_pkg::SAMPLE_W-1:0] taps [HISTORY_DEPTH],
    output logic      [parc_pkg::SAMPLE_W-1:0] pred
);

    logic signed [parc_pkg::SAMPLE_W:0] mid_sum;
    logic signed [parc_pkg::SAMPLE_W:0] side_diff;
    logic [parc_pkg::SAMPLE_W-1:0]      mid_avg;
    logic [parc_pkg::SAMPLE_W-1:0]      side_avg;
    logic [parc_pkg::SAMPLE_W-1:0]      a1;
    logic [parc_pkg::SAMPLE_W-1:0]      a2;
    logic [parc_pkg::SAMPLE_W-1:0]      a3;

    // halve a 17-bit value, rounding toward zero
    function automatic logic [parc_pkg::SAMPLE_W-1:0] half_trunc(
        input logic signed [parc_pkg::SAMPLE_W:0] s
    );
        logic signed [parc_pkg::SAMPLE_W:0] adj;
        adj = s + (parc_pkg::SAMPLE_W+1)'(s[parc_pkg::SAMPLE_W]);
        return adj[parc_pkg::SAMPLE_W:1];
    endfunction

    // mid and side averages
    assign mid_sum   = (parc_pkg::SAMPLE_W+1)'($signed(taps[1]))
                     + (parc_pkg::SAMPLE_W+1)'($signed(taps[3]));
    assign side_diff = (parc_pkg::SAMPLE_W+1)'($signed(taps[2]))
                     - (parc_pkg::SAMPLE_W+1)'($signed(taps[5]));
    assign mid_avg   = half_trunc(mid_sum);
    assign side_avg  = half_trunc(side_diff);

    // tap selection by channel layout
    always_comb
    begin
        a1 = taps[0];
        a2 = taps[1];
        a3 = taps[2];
        if (cfg.stereo)
        begin
            case (cfg.chan_mode)
                parc_pkg::MODE_MID:
                begin
                    a1 = mid_avg;
                    a2 = '0;
                    a3 = '0;
                end
                parc_pkg::MODE_SIDE:
                begin
                    a1 = side_avg;
                    a2 = '0;
                    a3 = '0;
                end
                default:
                begin
                    a1 = taps[1];
                    a2 = taps[3];
                    a3 = taps[5];
                end
            endcase
        end
    end

    // polynomial, modulo 2^16 since the result wraps anyway
    always_comb
    begin
        case (cfg.order)
            parc_pkg::ORDER_2: pred = (a1 << 1) - a2;
            parc_pkg::ORDER_3: pred = (a1 << 1) + a1 - ((a2 << 1) + a2) + a3;
            default:           pred = a1;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/polynomial_audio_residual_codec.sv @@
// ----------------------------------------------------------------------------
// polynomial_audio_residual_codec
// residual encoder and decoder with a fixed polynomial predictor
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid / in_stall carries sample_value and start_of_block,
//   a transfer happens when in_valid is high and in_stall is low
//   output channel out_valid / out_stall carries result_value
//   config channel cfg_valid / cfg_ready writes cfg_data into register
//   cfg_index (0 order, 1 channel mode, 2 stereo interleaved, 3 decode);
//   cfg_ready is always high, write only while no item is in flight
// path: each item passes the input register, then the result register,
//   before out_valid rises for it
// throughput: one item per cycle while out_stall is low; the history update and
//   the prediction sit in the single stage between the input and the result register
// reset: history cleared, order 1, mono, no channel correlation, encode
// stall: an output stall holds the result register; the input register
//   still takes one item, after which in_stall rises until the result
//   is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "polynomial_audio_residual_codec_assert.svh"

module polynomial_audio_residual_codec #(
    parameter int HISTORY_DEPTH = 6
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input samples
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [parc_pkg::SAMPLE_W-1:0]   sample_value,
    input  wire logic                            start_of_block,
    // results
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [parc_pkg::SAMPLE_W-1:0]   result_value,
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [parc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [parc_pkg::CFG_DATA_W-1:0] cfg_data
);

    parc_pkg::cfg_t                cfg_reg;
    parc_pkg::cfg_t                cfg_next;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [parc_pkg::SAMPLE_W-1:0] s1_sample_reg;
    logic                          s1_sob_reg;

    logic                          res_valid_reg;
    logic                          res_valid_next;
    logic [parc_pkg::SAMPLE_W-1:0] result_reg;
    logic [parc_pkg::SAMPLE_W-1:0] result_next;

    logic                          advance;
    logic                          mid_xfer;
    logic [parc_pkg::SAMPLE_W-1:0] pred;
    logic [parc_pkg::SAMPLE_W-1:0] stored;
    logic [parc_pkg::SAMPLE_W-1:0] taps [HISTORY_DEPTH];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (parc_pkg::cfg_reg_t'(cfg_index))
                parc_pkg::REG_ORDER:     cfg_next.order     = cfg_data[1:0];
                parc_pkg::REG_CHAN_MODE: cfg_next.chan_mode = cfg_data[1:0];
                parc_pkg::REG_STEREO:    cfg_next.stereo    = cfg_data[0];
                parc_pkg::REG_DECODE:    cfg_next.decode    = cfg_data[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.order     <= parc_pkg::ORDER_1;
            cfg_reg.chan_mode <= parc_pkg::MODE_NONE;
            cfg_reg.stereo    <= 1'b0;
            cfg_reg.decode    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // flow control between the two register stages
    assign advance  = !res_valid_reg || !out_stall;
    assign mid_xfer = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    assign s1_valid_next  = in_stall ? 1'b1 : in_valid;
    assign res_valid_next = advance ? s1_valid_reg : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            s1_sample_reg <= sample_value;
            s1_sob_reg    <= start_of_block;
        end
    end

    // sample history
    parc_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (s1_sob_reg),
        .shift      (mid_xfer),
        .new_sample (stored),
        .taps       (taps)
    );

    // prediction
    parc_predict #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_predict (
        .cfg  (cfg_reg),
        .taps (taps),
        .pred (pred)
    );

    // residual or rebuilt sample
    always_comb
    begin
        if (cfg_reg.decode)
        begin
            result_next = s1_sample_reg + pred;
            stored      = result_next;
        end
        else
        begin
            result_next = s1_sample_reg - pred;
            stored      = s1_sample_reg;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (mid_xfer)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = res_valid_reg;
    assign result_value = result_reg;

    // stall only when an item is actually waiting
    `PARC_ASSERT_IMP(a_stall_full, in_stall, s1_valid_reg)
    // an item leaving the input register lands in the result register
    `PARC_ASSERT_NXT(a_mid_lands, mid_xfer, res_valid_reg)
    // encode result is the sample minus the prediction
    `PARC_ASSERT_NXT(a_enc_res, mid_xfer && !cfg_reg.decode, result_reg == $past(result_next))

endmodule

`default_nettype wire

@@ test/tb_polynomial_audio_residual_codec.sv @@
// ----------------------------------------------------------------------------
// tb_polynomial_audio_residual_codec
// self-checking bench for the polynomial residual encoder and decoder
// ----------------------------------------------------------------------------
// a behavioral copy of the predictor (history, taps, order, stereo modes)
// computes each expected result as the input transfer happens; a checker
// compares every output transfer against the oldest expected value. the run
// starts with short directed sequences at the sample extremes for a range of
// settings and a mid-block pause until drained, then random blocks of audio-like and full-range data under every
// order / channel mode / stereo combination, with random gaps on the input
// side and random stalls on the output side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_polynomial_audio_residual_codec;

    // dut signals
    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [parc_pkg::SAMPLE_W-1:0]   sample_value;
    logic                            start_of_block;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [parc_pkg::SAMPLE_W-1:0]   result_value;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [parc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [parc_pkg::CFG_DATA_W-1:0] cfg_data;

    // predictor copy: configuration and sample history
    logic [1:0]                           m_order  = parc_pkg::ORDER_1;
    logic [1:0]                           m_mode   = parc_pkg::MODE_NONE;
    logic                                 m_stereo = 1'b0;
    logic                                 m_decode = 1'b0;
    logic signed [parc_pkg::SAMPLE_W-1:0] sample_hist [6];

    // results still owed by the dut
    logic [parc_pkg::SAMPLE_W-1:0] pending_results [$];
    logic [parc_pkg::SAMPLE_W-1:0] exp_val;

    int  errors        = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  cfg_writes    = 0;
    int  stall_left    = 0;
    bit  no_idle       = 1'b0;

    polynomial_audio_residual_codec DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_value   (sample_value),
        .start_of_block (start_of_block),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_value   (result_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // history tap, lag n in 1..6
    function automatic int hist_lag(input int n);
        return int'(sample_hist[n-1]);
    endfunction

    // polynomial over three taps, order 0 falls back to first order
    function automatic int poly_taps(input int a1, input int a2, input int a3);
        if (m_order == parc_pkg::ORDER_2)
            return 2 * a1 - a2;
        if (m_order == parc_pkg::ORDER_3)
            return 3 * a1 - 3 * a2 + a3;
        return a1;
    endfunction

    // residual or rebuilt sample for one input, advances the history
    function automatic logic [parc_pkg::SAMPLE_W-1:0] compute_result(
        input logic [parc_pkg::SAMPLE_W-1:0] x,
        input logic                          sob
    );
        int                            pred;
        int                            avg;
        int                            sum;
        logic [parc_pkg::SAMPLE_W-1:0] res;
        logic [parc_pkg::SAMPLE_W-1:0] stored;
        if (sob)
            foreach (sample_hist[k])
                sample_hist[k] = '0;
        // tap selection; channel mode three acts as no correlation
        if (!m_stereo)
            pred = poly_taps(hist_lag(1), hist_lag(2), hist_lag(3));
        else if (m_mode == parc_pkg::MODE_MID)
        begin
            avg  = (hist_lag(2) + hist_lag(4)) / 2;
            pred = poly_taps(avg, 0, 0);
        end
        else if (m_mode == parc_pkg::MODE_SIDE)
        begin
            avg  = (hist_lag(3) - hist_lag(6)) / 2;
            pred = poly_taps(avg, 0, 0);
        end
        else
            pred = poly_taps(hist_lag(2), hist_lag(4), hist_lag(6));
        // wrap to 16 bits
        if (m_decode)
        begin
            sum    = int'($signed(x)) + pred;
            res    = sum[parc_pkg::SAMPLE_W-1:0];
            stored = res;
        end
        else
        begin
            sum    = int'($signed(x)) - pred;
            res    = sum[parc_pkg::SAMPLE_W-1:0];
            stored = x;
        end
        for (int k = 5; k > 0; k--)
            sample_hist[k] = sample_hist[k-1];
        sample_hist[0] = stored;
        return res;
    endfunction

    // random sample: near the previous one, full range, extremes or small
    function automatic logic [parc_pkg::SAMPLE_W-1:0] gen_sample(
        input logic [parc_pkg::SAMPLE_W-1:0] prev
    );
        int r;
        int pick;
        r = $urandom_range(0, 99);
        if (r < 40)
            return prev + parc_pkg::SAMPLE_W'($urandom_range(0, 512))
                        - parc_pkg::SAMPLE_W'(256);
        if (r < 70)
            return parc_pkg::SAMPLE_W'($urandom());
        if (r < 85)
        begin
            pick = $urandom_range(0, 4);
            case (pick)
                0:       return 16'h7fff;
                1:       return 16'h8000;
                2:       return 16'h0000;
                3:       return 16'hffff;
                default: return 16'h0001;
            endcase
        end
        return parc_pkg::SAMPLE_W'($urandom_range(0, 64)) - parc_pkg::SAMPLE_W'(32);
    endfunction

    // one input transfer; the expected result is computed as it is taken
    task automatic send_sample(input logic [parc_pkg::SAMPLE_W-1:0] v, input logic sob);
        int                            gap;
        logic [parc_pkg::SAMPLE_W-1:0] expected;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        sample_value   <= v;
        start_of_block <= sob;
        do
            @(posedge clk);
        while (in_stall);
        expected = compute_result(v, sob);
        pending_results.insert(pending_results.size(), expected);
        items_sent++;
    endtask

    // directed block, first item opens a fresh block
    task automatic send_block(input logic [parc_pkg::SAMPLE_W-1:0] vals [$]);
        foreach (vals[i])
            send_sample(vals[i], i == 0);
    endtask

    // sender pauses until every owed result has come, then pipeline settles
    task automatic drain_results();
        int waited;
        waited = 0;
        if (in_valid)
            in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending_results.size() != 0 && waited < 100_000);
        repeat (3) @(posedge clk);
    endtask

    // writes all four registers, upper data bits carry junk
    task automatic write_config(input logic [1:0] order, input logic [1:0] mode,
                                input logic stereo, input logic decode);
        parc_pkg::cfg_reg_t              regs [4];
        logic [parc_pkg::CFG_DATA_W-1:0] vals [4];
        regs = '{parc_pkg::REG_ORDER, parc_pkg::REG_CHAN_MODE,
                 parc_pkg::REG_STEREO, parc_pkg::REG_DECODE};
        vals[0] = {6'($urandom()), order};
        vals[1] = {6'($urandom()), mode};
        vals[2] = {7'($urandom()), stereo};
        vals[3] = {7'($urandom()), decode};
        drain_results();
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_writes++;
        end
        cfg_valid <= 1'b0;
        m_order  = order;
        m_mode   = mode;
        m_stereo = stereo;
        m_decode = decode;
    endtask

    // reset values: first order mono encode
    task automatic test_reset_defaults();
        send_block('{16'h7fff, 16'h8000, 16'h0000});
    endtask

    // extremes under orders 0, 2 and 3, both directions, every channel mode
    task automatic test_directed_extremes();
        write_config(parc_pkg::ORDER_3, parc_pkg::MODE_NONE, 1'b0, 1'b0);
        send_block('{16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
        // order zero behaves as first order
        write_config(2'd0, parc_pkg::MODE_NONE, 1'b0, 1'b1);
        send_block('{16'h7fff, 16'h0001, 16'h8000});
        write_config(parc_pkg::ORDER_3, parc_pkg::MODE_NONE, 1'b1, 1'b0);
        send_block('{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
        write_config(parc_pkg::ORDER_2, parc_pkg::MODE_MID, 1'b1, 1'b1);
        send_block('{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000});
        write_config(parc_pkg::ORDER_3, parc_pkg::MODE_SIDE, 1'b1, 1'b0);
        send_block('{16'h8000, 16'h0001, 16'h7fff, 16'hffff, 16'h8000});
        // channel mode three behaves as no correlation
        write_config(parc_pkg::ORDER_2, 2'd3, 1'b1, 1'b0);
        send_block('{16'h7fff, 16'h8000});
    endtask

    // random blocks under every order / mode / stereo combination
    task automatic test_random_streams();
        int                            phase_items;
        int                            block_left;
        logic [parc_pkg::SAMPLE_W-1:0] prev;
        logic [parc_pkg::SAMPLE_W-1:0] v;
        logic                          sob;
        logic [1:0]                    ord;
        logic [1:0]                    mode;
        logic                          stereo;
        logic                          decode;
        prev = '0;
        for (int c = 0; c < 36; c++)
        begin
            if (c < 32)
            begin
                ord    = c[1:0];
                mode   = c[3:2];
                stereo = c[4];
            end
            else
            begin
                ord    = 2'($urandom());
                mode   = 2'($urandom());
                stereo = 1'($urandom());
            end
            decode = 1'($urandom());
            write_config(ord, mode, stereo, decode);
            no_idle     = ($urandom_range(0, 4) == 0);
            phase_items = $urandom_range(24, 36);
            block_left  = 0;
            for (int n = 0; n < phase_items; n++)
            begin
                // mostly well-formed blocks, a stray block start now and then
                if (block_left == 0)
                begin
                    sob        = ($urandom_range(0, 9) != 0);
                    block_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 20);
                end
                else
                    sob = ($urandom_range(0, 39) == 0);
                block_left--;
                v = gen_sample(prev);
                send_sample(v, sob);
                prev = v;
            end
            no_idle = 1'b0;
        end
    endtask

    // sender holds off mid-block until the pipeline is empty, then resumes
    task automatic test_pause_until_drained();
        logic [parc_pkg::SAMPLE_W-1:0] v;
        v = '0;
        write_config(parc_pkg::ORDER_3, parc_pkg::MODE_NONE, 1'b1, 1'b1);
        for (int n = 0; n < 20; n++)
        begin
            if (n == 10)
                drain_results();
            v = gen_sample(v);
            send_sample(v, n == 0);
        end
    endtask

    // output stalls, random lengths, none while no_idle is set
    always @(posedge clk)
    begin
        if (no_idle || stall_left == 0)
        begin
            out_stall <= 1'b0;
            if (!no_idle && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
        else
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
    end

    // compare each output transfer against the oldest expected result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result_value with nothing expected: actual %0d", $signed(result_value));
                errors++;
            end
            else
            begin
                exp_val = pending_results.pop_front();
                results_seen++;
                if (result_value !== exp_val)
                begin
                    $error("result_value mismatch: expected %0d actual %0d",
                           $signed(exp_val), $signed(result_value));
                    errors++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        foreach (sample_hist[k])
            sample_hist[k] = '0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sample_value   = '0;
        start_of_block = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = parc_pkg::REG_ORDER;
        cfg_data       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_extremes();
        test_pause_until_drained();
        test_random_streams();

        drain_results();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end
        $display("covered %0d samples and %0d results over %0d register writes,",
                 items_sent, results_seen, cfg_writes);
        $display("all orders, mono and stereo with every channel mode, encode and decode");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
